FILE: sv/glzw_pkg.sv
// Shared types, constants and helpers for the GIF LZW decoder.
package glzw_pkg;

	localparam int DICT_SIZE_DEF     = 4096;
	localparam int MAX_CODE_BITS_DEF = 12;
	localparam int CODE_W            = 12;
	localparam int STACK_DEPTH       = 4096;
	localparam int STACK_AW          = 12;
	localparam int STACK_BOUND       = 4094;
	localparam int BUF_W             = 24;

	localparam logic [2:0] ST_TAKEN   = 3'd0;
	localparam logic [2:0] ST_REFUSED = 3'd1;
	localparam logic [2:0] ST_PIXEL   = 3'd2;
	localparam logic [2:0] ST_NEED    = 3'd3;
	localparam logic [2:0] ST_ENDED   = 3'd4;

	localparam logic CFG_MIN_CODE   = 1'b0;
	localparam logic CFG_LINE_WIDTH = 1'b1;

	localparam logic [3:0] MIN_CODE_RESET   = 4'd8;
	localparam logic [15:0] LINE_WIDTH_RESET = 16'd256;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH,
		S_CHK,
		S_POPW,
		S_WALK,
		S_WRD
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_PUSH,
		OP_POP_RD,
		OP_EMIT_PIX,
		OP_SHORT,
		OP_CLEAR,
		OP_END,
		OP_LIT,
		OP_DEC,
		OP_WALK_RD,
		OP_WALK_PUSH,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic in_func;
		logic level_zero;
		logic bits_short;
		logic code_clear;
		logic code_end;
		logic after_clear;
		logic walk_go;
		logic out_free;
	} stat_t;

	function automatic logic [3:0] eff_min(input logic [3:0] m);
		logic [3:0] r;
		r = m;
		if (m < 4'd2) r = 4'd2;
		if (m > 4'd9) r = 4'd9;
		return r;
	endfunction

endpackage

FILE: sv/gif_lzw_decoder_unit.sv
// Top level of the GIF LZW decoder: controller, datapath and port glue.
// A push is latched, then its result is registered once the output is free; a pull
// that pops a stacked pixel goes through the registered read of the pixel stack RAM.
// A pull on an empty stack first handles each clear or literal code in the check
// state, and a code with a chain walk alternates table reads and stack pushes.
// Reset is asynchronous and active low; the tables and stack need no clearing pass.
module gif_lzw_decoder_unit #(
	parameter int DICT_SIZE     = glzw_pkg::DICT_SIZE_DEF,
	parameter int MAX_CODE_BITS = glzw_pkg::MAX_CODE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  pixel,
	output logic        end_of_row,
	output logic        bad_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	glzw_pkg::cmd_t  cmd;
	glzw_pkg::stat_t st;

	assign cfg_ready = 1'b1;

	glzw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	glzw_dp #(.DICT_SIZE(DICT_SIZE), .MAX_CODE_BITS(MAX_CODE_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.func       (func),
		.data_byte  (data_byte),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.pixel      (pixel),
		.end_of_row (end_of_row),
		.bad_code   (bad_code)
	);

endmodule

FILE: sv/glzw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module glzw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/glzw_ctrl.sv
// Sequencing state machine for the GIF LZW decoder.
module glzw_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  glzw_pkg::stat_t st,
	output glzw_pkg::cmd_t  cmd
);

	glzw_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= glzw_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = glzw_pkg::OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			glzw_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = glzw_pkg::OP_LATCH;
					state_d = st.in_func ? glzw_pkg::S_CHK : glzw_pkg::S_PUSH;
				end
			end
			glzw_pkg::S_PUSH: begin
				if (st.out_free) begin
					cmd.op  = glzw_pkg::OP_PUSH;
					state_d = glzw_pkg::S_IDLE;
				end
			end
			glzw_pkg::S_CHK: begin
				if (!st.out_free) begin
					cmd.op = glzw_pkg::OP_NONE;
				end else if (!st.level_zero) begin
					cmd.op  = glzw_pkg::OP_POP_RD;
					state_d = glzw_pkg::S_POPW;
				end else if (st.bits_short) begin
					cmd.op  = glzw_pkg::OP_SHORT;
					state_d = glzw_pkg::S_IDLE;
				end else if (st.code_clear) begin
					cmd.op = glzw_pkg::OP_CLEAR;
				end else if (st.code_end) begin
					cmd.op  = glzw_pkg::OP_END;
					state_d = glzw_pkg::S_IDLE;
				end else if (st.after_clear) begin
					cmd.op = glzw_pkg::OP_LIT;
				end else begin
					cmd.op  = glzw_pkg::OP_DEC;
					state_d = glzw_pkg::S_WALK;
				end
			end
			glzw_pkg::S_POPW: begin
				if (st.out_free) begin
					cmd.op  = glzw_pkg::OP_EMIT_PIX;
					state_d = glzw_pkg::S_IDLE;
				end
			end
			glzw_pkg::S_WALK: begin
				if (st.walk_go) begin
					cmd.op  = glzw_pkg::OP_WALK_RD;
					state_d = glzw_pkg::S_WRD;
				end else begin
					cmd.op  = glzw_pkg::OP_FINISH;
					state_d = glzw_pkg::S_CHK;
				end
			end
			glzw_pkg::S_WRD: begin
				cmd.op  = glzw_pkg::OP_WALK_PUSH;
				state_d = glzw_pkg::S_WALK;
			end
			default: begin
				state_d = glzw_pkg::S_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/glzw_dp.sv
// Datapath of the GIF LZW decoder: bit buffer, tables, pixel stack and result register.
module glzw_dp #(
	parameter int DICT_SIZE     = glzw_pkg::DICT_SIZE_DEF,
	parameter int MAX_CODE_BITS = glzw_pkg::MAX_CODE_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  glzw_pkg::cmd_t  cmd,
	output glzw_pkg::stat_t st,
	input  logic            func,
	input  logic [7:0]      data_byte,
	input  logic            cfg_valid,
	input  logic            cfg_index,
	input  logic [15:0]     cfg_data,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [2:0]      status,
	output logic [7:0]      pixel,
	output logic            end_of_row,
	output logic            bad_code
);

	localparam int AW = $clog2(DICT_SIZE);
	localparam int CW = glzw_pkg::CODE_W;
	localparam int BW = glzw_pkg::BUF_W;

	logic [3:0]    msize_q;
	logic [15:0]   lwidth_q;
	logic [12:0]   level_q, next_q, limit_q;
	logic [3:0]    cw_q;
	logic [CW-1:0] old_q, cur_q, c_q;
	logic [7:0]    first_q, byte_q;
	logic [BW-1:0] buf_q;
	logic [4:0]    bc_q;
	logic [7:0]    left_q;
	logic [15:0]   row_q;
	logic          after_q, fin_q, badp_q, inr_q;
	logic          out_valid_q;
	logic [2:0]    status_q;
	logic [7:0]    pixel_q;
	logic          eor_q, bad_q;

	logic [12:0]   clear_code, roots;
	logic [BW-1:0] mask, buf_shift;
	logic [CW-1:0] code;
	logic          out_free;

	logic          sk_we, sk_re;
	logic [glzw_pkg::STACK_AW-1:0] sk_waddr, sk_raddr;
	logic [7:0]    sk_wdata, sk_rdata;
	logic          tb_we, tb_re;
	logic [AW-1:0] tb_waddr, tb_raddr;
	logic [7:0]    suf_rdata;
	logic [CW-1:0] pre_rdata;

	assign clear_code = 13'(1) << msize_q;
	assign roots      = clear_code + 13'd2;
	assign mask       = (BW'(1) << cw_q) - BW'(1);
	assign code       = CW'(buf_q & mask);
	assign buf_shift  = buf_q >> cw_q;
	assign out_free   = !out_valid_q || out_ready;

	assign st.in_func     = func;
	assign st.level_zero  = (level_q == 13'd0);
	assign st.bits_short  = ({1'b0, bc_q} < {2'b00, cw_q});
	assign st.code_clear  = ({1'b0, code} == clear_code);
	assign st.code_end    = ({1'b0, code} == clear_code + 13'd1);
	assign st.after_clear = after_q;
	assign st.walk_go     = ({1'b0, cur_q} >= roots) &&
		(level_q < 13'(glzw_pkg::STACK_BOUND));
	assign st.out_free    = out_free;

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign pixel      = pixel_q;
	assign end_of_row = eor_q;
	assign bad_code   = bad_q;

	// Stack and table port control.
	always_comb begin
		sk_we    = 1'b0;
		sk_wdata = first_q;
		sk_re    = (cmd.op == glzw_pkg::OP_POP_RD);
		sk_raddr = glzw_pkg::STACK_AW'(level_q - 13'd1);
		sk_waddr = glzw_pkg::STACK_AW'(level_q);
		tb_re    = (cmd.op == glzw_pkg::OP_WALK_RD);
		tb_raddr = AW'(cur_q);
		tb_waddr = AW'(next_q);
		tb_we    = 1'b0;
		case (cmd.op)
			glzw_pkg::OP_LIT: begin
				sk_we    = 1'b1;
				sk_wdata = ({1'b0, code} >= next_q) ? 8'd0 : code[7:0];
			end
			glzw_pkg::OP_DEC: begin
				sk_we    = ({1'b0, code} >= next_q) &&
					(level_q < 13'(glzw_pkg::STACK_BOUND));
				sk_wdata = first_q;
			end
			glzw_pkg::OP_WALK_PUSH: begin
				sk_we    = 1'b1;
				sk_wdata = inr_q ? suf_rdata : 8'd0;
			end
			glzw_pkg::OP_FINISH: begin
				sk_we    = 1'b1;
				sk_wdata = cur_q[7:0];
				tb_we    = (next_q < limit_q) && (next_q < 13'(DICT_SIZE));
			end
			default: begin
				sk_we = 1'b0;
			end
		endcase
	end

	glzw_ram #(.WIDTH(8), .DEPTH(glzw_pkg::STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (sk_we),
		.waddr (sk_waddr),
		.wdata (sk_wdata),
		.re    (sk_re),
		.raddr (sk_raddr),
		.rdata (sk_rdata)
	);

	glzw_ram #(.WIDTH(8), .DEPTH(DICT_SIZE)) u_suffix (
		.clk   (clk),
		.we    (tb_we),
		.waddr (tb_waddr),
		.wdata (cur_q[7:0]),
		.re    (tb_re),
		.raddr (tb_raddr),
		.rdata (suf_rdata)
	);

	glzw_ram #(.WIDTH(CW), .DEPTH(DICT_SIZE)) u_prefix (
		.clk   (clk),
		.we    (tb_we),
		.waddr (tb_waddr),
		.wdata (old_q),
		.re    (tb_re),
		.raddr (tb_raddr),
		.rdata (pre_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		logic [3:0]  eff;
		logic [12:0] ns;
		logic [16:0] rc1;
		logic [15:0] lw;
		logic        emit;
		if (!arst_n) begin
			msize_q     <= glzw_pkg::MIN_CODE_RESET;
			lwidth_q    <= glzw_pkg::LINE_WIDTH_RESET;
			cw_q        <= glzw_pkg::MIN_CODE_RESET + 4'd1;
			limit_q     <= 13'(1) << (glzw_pkg::MIN_CODE_RESET + 4'd1);
			next_q      <= (13'(1) << glzw_pkg::MIN_CODE_RESET) + 13'd2;
			level_q     <= '0;
			old_q       <= '0;
			first_q     <= '0;
			buf_q       <= '0;
			bc_q        <= '0;
			left_q      <= '0;
			row_q       <= '0;
			after_q     <= 1'b0;
			fin_q       <= 1'b0;
			badp_q      <= 1'b0;
			inr_q       <= 1'b0;
			cur_q       <= '0;
			c_q         <= '0;
			byte_q      <= '0;
			out_valid_q <= 1'b0;
			status_q    <= '0;
			pixel_q     <= '0;
			eor_q       <= 1'b0;
			bad_q       <= 1'b0;
		end else begin
			emit = cmd.op inside {glzw_pkg::OP_PUSH, glzw_pkg::OP_EMIT_PIX,
				glzw_pkg::OP_SHORT, glzw_pkg::OP_END};
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				if (cfg_index == glzw_pkg::CFG_MIN_CODE) begin
					eff      = glzw_pkg::eff_min(cfg_data[3:0]);
					msize_q  <= eff;
					cw_q     <= eff + 4'd1;
					limit_q  <= 13'(1) << (eff + 4'd1);
					next_q   <= (13'(1) << eff) + 13'd2;
					level_q  <= '0;
					old_q    <= '0;
					first_q  <= '0;
					buf_q    <= '0;
					bc_q     <= '0;
					left_q   <= '0;
					row_q    <= '0;
					after_q  <= 1'b0;
					fin_q    <= 1'b0;
					badp_q   <= 1'b0;
				end else begin
					lwidth_q <= cfg_data;
				end
			end
			case (cmd.op)
				glzw_pkg::OP_LATCH: begin
					byte_q <= data_byte;
				end
				glzw_pkg::OP_PUSH: begin
					status_q <= (!fin_q && left_q != 8'd0 && bc_q > 5'd16) ?
						glzw_pkg::ST_REFUSED : glzw_pkg::ST_TAKEN;
					pixel_q  <= '0;
					eor_q    <= 1'b0;
					bad_q    <= 1'b0;
					if (!fin_q) begin
						if (left_q == 8'd0) begin
							if (byte_q == 8'd0) fin_q <= 1'b1;
							else left_q <= byte_q;
						end else if (bc_q <= 5'd16) begin
							buf_q  <= buf_q | (BW'(byte_q) << bc_q);
							bc_q   <= bc_q + 5'd8;
							left_q <= left_q - 8'd1;
						end
					end
				end
				glzw_pkg::OP_POP_RD: begin
					level_q <= level_q - 13'd1;
				end
				glzw_pkg::OP_EMIT_PIX: begin
					lw  = (lwidth_q == 16'd0) ? 16'd1 : lwidth_q;
					rc1 = {1'b0, row_q} + 17'd1;
					status_q    <= glzw_pkg::ST_PIXEL;
					pixel_q     <= sk_rdata;
					bad_q       <= badp_q;
					if (rc1 >= {1'b0, lw}) begin
						row_q <= '0;
						eor_q <= 1'b1;
					end else begin
						row_q <= rc1[15:0];
						eor_q <= 1'b0;
					end
				end
				glzw_pkg::OP_SHORT: begin
					status_q    <= fin_q ? glzw_pkg::ST_ENDED : glzw_pkg::ST_NEED;
					pixel_q     <= '0;
					eor_q       <= 1'b0;
					bad_q       <= 1'b0;
				end
				glzw_pkg::OP_CLEAR: begin
					buf_q   <= buf_shift;
					bc_q    <= bc_q - {1'b0, cw_q};
					cw_q    <= msize_q + 4'd1;
					limit_q <= 13'(1) << (msize_q + 4'd1);
					next_q  <= clear_code + 13'd2;
					after_q <= 1'b1;
				end
				glzw_pkg::OP_END: begin
					fin_q       <= 1'b1;
					buf_q       <= '0;
					bc_q        <= '0;
					status_q    <= glzw_pkg::ST_ENDED;
					pixel_q     <= '0;
					eor_q       <= 1'b0;
					bad_q       <= 1'b0;
				end
				glzw_pkg::OP_LIT: begin
					buf_q   <= buf_shift;
					bc_q    <= bc_q - {1'b0, cw_q};
					old_q   <= ({1'b0, code} >= next_q) ? '0 : code;
					first_q <= ({1'b0, code} >= next_q) ? 8'd0 : code[7:0];
					badp_q  <= 1'b0;
					level_q <= level_q + 13'd1;
					after_q <= 1'b0;
				end
				glzw_pkg::OP_DEC: begin
					buf_q  <= buf_shift;
					bc_q   <= bc_q - {1'b0, cw_q};
					c_q    <= code;
					if (sk_we) begin
						badp_q  <= ({1'b0, code} > next_q);
						cur_q   <= old_q;
						level_q <= level_q + 13'd1;
					end else begin
						badp_q  <= 1'b0;
						cur_q   <= code;
					end
				end
				glzw_pkg::OP_WALK_RD: begin
					inr_q <= (32'(cur_q) < DICT_SIZE);
				end
				glzw_pkg::OP_WALK_PUSH: begin
					level_q <= level_q + 13'd1;
					cur_q   <= inr_q ? pre_rdata : '0;
				end
				glzw_pkg::OP_FINISH: begin
					level_q <= level_q + 13'd1;
					ns = next_q;
					if (tb_we) begin
						first_q <= cur_q[7:0];
						old_q   <= c_q;
						ns      = next_q + 13'd1;
					end
					next_q <= ns;
					if ((ns >= limit_q) && (32'(cw_q) < MAX_CODE_BITS)) begin
						limit_q <= limit_q << 1;
						cw_q    <= cw_q + 4'd1;
					end
				end
				default: begin
					byte_q <= byte_q;
				end
			endcase
		end
	end

endmodule

FILE: sv/glzw_chk.sv
// Port-level checker for the GIF LZW decoder, bound to the top level.
module glzw_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] status,
	input logic [7:0] pixel,
	input logic       end_of_row,
	input logic       bad_code
);

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= glzw_pkg::ST_ENDED))
		else $error("status code out of range");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != glzw_pkg::ST_PIXEL) |->
		(pixel == 8'd0 && !end_of_row && !bad_code))
		else $error("pixel fields set on a non-pixel result");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(pixel)))
		else $error("stalled result changed");

endmodule

bind gif_lzw_decoder_unit glzw_chk u_glzw_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.pixel      (pixel),
	.end_of_row (end_of_row),
	.bad_code   (bad_code)
);
